// ===== design/cdo_pkg.sv =====
// Shared widths, constants and calendar tables for the date offset pipeline.
`timescale 1ns / 1ps
`default_nettype none

package cdo_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int OFFSET_W   = 16;
  localparam int WDAY_W     = 3;
  localparam int IN_W       = 64;
  localparam int OUT_W      = 32;

  // Day number counted from March 1 of year -400, always positive here.
  localparam int DAYNUM_W   = 23;
  localparam int ERA_W      = 6;
  localparam int DOE_W      = 18;
  localparam int YOE_W      = 9;
  localparam int DOY_W      = 9;
  localparam int RYEAR_W    = 16;

  // Pipeline stages in front of the output register.
  localparam int STAGES     = 11;

  localparam int YEAR_MIN   = 1900;
  localparam int YEAR_MAX   = 9999;
  localparam int MONTHS     = 12;
  localparam int DAYS_YEAR  = 365;
  localparam int DAYS_4Y    = 1460;
  localparam int DAYS_100Y  = 36524;
  localparam int DAYS_400Y  = 146097;
  localparam int CENTURY    = 100;
  localparam int ERA_YEARS  = 400;
  localparam int WDAY_BIAS  = 3;
  localparam int WDAYS      = 7;

  // Reciprocals scaled by two to the RECIP_SH; the quotient estimate is at most one low.
  localparam int RECIP_SH   = 32;
  localparam logic [25:0] R_CENTURY = 26'((64'd1 << RECIP_SH) / 64'd100);
  localparam logic [14:0] R_ERA     = 15'((64'd1 << RECIP_SH) / 64'd146097);
  localparam logic [21:0] R_4Y      = 22'((64'd1 << RECIP_SH) / 64'd1460);
  localparam logic [16:0] R_100Y    = 17'((64'd1 << RECIP_SH) / 64'd36524);
  localparam logic [23:0] R_YEAR    = 24'((64'd1 << RECIP_SH) / 64'd365);

  // Month index counted from March, after the month has been carried into the year.
  function automatic logic [MONTH_W-1:0] month_index(input logic [MONTH_W-1:0] month);
    logic [MONTH_W-1:0] idx;
    unique case (month)
      4'd0:    idx = 4'd9;
      4'd1:    idx = 4'd10;
      4'd2:    idx = 4'd11;
      4'd13:   idx = 4'd10;
      4'd14:   idx = 4'd11;
      4'd15:   idx = 4'd0;
      default: idx = month - 4'd3;
    endcase
    return idx;
  endfunction

  // First day of each month within a year that starts on March 1.
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] start;
    unique case (idx)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               after;
    logic               earlier;
    logic               same;
  } side_t;

endpackage

`default_nettype wire

// ===== design/cdo_to_days.sv =====
// Three-stage conversion of a carried base date plus offset into a day number.
`timescale 1ns / 1ps
`default_nettype none

module cdo_to_days (
  input  logic                               clk,
  input  logic                               en,
  input  logic [cdo_pkg::YEAR_W-1:0]         base_year,
  input  logic [cdo_pkg::MONTH_W-1:0]        base_month,
  input  logic [cdo_pkg::DAY_W-1:0]          base_day,
  input  logic signed [cdo_pkg::OFFSET_W-1:0] day_offset,
  output logic [cdo_pkg::DAYNUM_W-1:0]       day_num
);

  logic [8:0]         year_bias;
  logic [14:0]        shifted_year;
  logic signed [17:0] day_sum;

  logic [14:0]        y1;
  logic signed [17:0] dsum1;

  logic [40:0]        p_cent;
  logic [22:0]        ybase;
  logic [14:0]        y2;
  logic [7:0]         cent_est2;
  logic [22:0]        ybase2;
  logic signed [17:0] dsum2;

  logic [14:0]        cent_rem;
  logic [7:0]         cent;
  logic signed [24:0] nsum;

  // Months 0 to 2 fall in the year before for a March-based year; month 15 is March of the next.
  always_comb begin
    priority if (base_month <= 4'd2) begin
      year_bias = 9'd399;
    end else if (base_month == 4'd15) begin
      year_bias = 9'd401;
    end else begin
      year_bias = 9'd400;
    end
    shifted_year = 15'(base_year) + 15'(year_bias);
    day_sum = $signed(18'(cdo_pkg::month_start(cdo_pkg::month_index(base_month))))
            + $signed(18'(base_day)) - 18'sd1 + 18'(day_offset);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1    <= shifted_year;
      dsum1 <= day_sum;
    end
  end

  assign p_cent = 41'(y1) * 41'(cdo_pkg::R_CENTURY);
  assign ybase  = 23'(y1) * 23'(cdo_pkg::DAYS_YEAR) + 23'(y1 >> 2);

  always_ff @(posedge clk) begin
    if (en) begin
      y2        <= y1;
      cent_est2 <= p_cent[39:32];
      ybase2    <= ybase;
      dsum2     <= dsum1;
    end
  end

  // Leap days: add a quarter of the years, drop centuries, add back every fourth century.
  always_comb begin
    cent_rem = y2 - 15'(cent_est2) * 15'(cdo_pkg::CENTURY);
    cent     = cent_est2 + 8'(cent_rem >= 15'(cdo_pkg::CENTURY));
    nsum     = $signed(25'(ybase2)) - $signed(25'(cent)) + $signed(25'(cent >> 2))
             + 25'(dsum2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_num <= nsum[22:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/cdo_from_days.sv =====
// Eight-stage conversion of a day number back to year, month, day and weekday.
`timescale 1ns / 1ps
`default_nettype none

module cdo_from_days (
  input  logic                                clk,
  input  logic                                en,
  input  logic [cdo_pkg::DAYNUM_W-1:0]        day_num,
  output logic signed [cdo_pkg::RYEAR_W-1:0]  year,
  output logic [cdo_pkg::MONTH_W-1:0]         month,
  output logic [cdo_pkg::DAY_W-1:0]           day,
  output logic [cdo_pkg::WDAY_W-1:0]          weekday
);

  localparam int EW = cdo_pkg::ERA_W;
  localparam int DW = cdo_pkg::DOE_W;

  logic [37:0]   p_era;
  logic [22:0]   s4_n;
  logic [EW-1:0] s4_era_est;

  logic [22:0]   era_rem;
  logic [EW-1:0] s5_era;
  logic [DW-1:0] s5_doe;

  logic [39:0]   p_4y;
  logic [34:0]   p_100y;
  logic [5:0]    digit_sum;
  logic [3:0]    wd_fold;
  logic [EW-1:0] s6_era;
  logic [DW-1:0] s6_doe;
  logic [6:0]    s6_e4y;
  logic [2:0]    s6_e100y;
  logic          s6_last;
  logic [2:0]    s6_wd;

  logic [DW-1:0] rem_4y;
  logic [DW-1:0] rem_100y;
  logic [6:0]    q_4y;
  logic [2:0]    q_100y;
  logic [EW-1:0] s7_era;
  logic [DW-1:0] s7_doe;
  logic [DW-1:0] s7_x;
  logic [2:0]    s7_wd;

  logic [41:0]   p_year;
  logic [EW-1:0] s8_era;
  logic [DW-1:0] s8_doe;
  logic [DW-1:0] s8_x;
  logic [8:0]    s8_yest;
  logic [2:0]    s8_wd;

  logic [DW-1:0] rem_year;
  logic [EW-1:0] s9_era;
  logic [DW-1:0] s9_doe;
  logic [8:0]    s9_yoe;
  logic [2:0]    s9_wd;

  logic [1:0]    cents;
  logic [DW-1:0] doy_full;
  logic [EW-1:0] s10_era;
  logic [8:0]    s10_yoe;
  logic [8:0]    s10_doy;
  logic [2:0]    s10_wd;

  logic [3:0]    mp;
  logic [3:0]    month_calc;
  logic          jan_feb;

  // Stage 4: estimate of the 400-year era.
  assign p_era = 38'(day_num) * 38'(cdo_pkg::R_ERA);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_n       <= day_num;
      s4_era_est <= p_era[37:32];
    end
  end

  // Stage 5: correct the era and take the day within it.
  assign era_rem = s4_n - 23'(s4_era_est) * 23'(cdo_pkg::DAYS_400Y);

  always_ff @(posedge clk) begin
    if (en) begin
      if (era_rem >= 23'(cdo_pkg::DAYS_400Y)) begin
        s5_era <= s4_era_est + 6'd1;
        s5_doe <= DW'(era_rem - 23'(cdo_pkg::DAYS_400Y));
      end else begin
        s5_era <= s4_era_est;
        s5_doe <= DW'(era_rem);
      end
    end
  end

  // Stage 6: leap-cycle quotient estimates. An era is a whole number of weeks, so the
  // weekday follows from the day within the era; octal digits are summed since 8 is 1 mod 7.
  assign p_4y   = 40'(s5_doe) * 40'(cdo_pkg::R_4Y);
  assign p_100y = 35'(s5_doe) * 35'(cdo_pkg::R_100Y);

  always_comb begin
    digit_sum = 6'(cdo_pkg::WDAY_BIAS);
    for (int k = 0; k < DW / 3; k++) begin
      digit_sum = digit_sum + 6'(s5_doe[3*k +: 3]);
    end
    wd_fold = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_era   <= s5_era;
      s6_doe   <= s5_doe;
      s6_e4y   <= p_4y[38:32];
      s6_e100y <= p_100y[34:32];
      s6_last  <= (s5_doe == DW'(cdo_pkg::DAYS_400Y - 1));
      s6_wd    <= (wd_fold >= 4'(cdo_pkg::WDAYS)) ? 3'(wd_fold - 4'(cdo_pkg::WDAYS))
                                                  : 3'(wd_fold);
    end
  end

  // Stage 7: correct the quotients and remove the leap days from the day count.
  always_comb begin
    rem_4y   = s6_doe - DW'(s6_e4y) * DW'(cdo_pkg::DAYS_4Y);
    rem_100y = s6_doe - DW'(s6_e100y) * DW'(cdo_pkg::DAYS_100Y);
    q_4y     = s6_e4y + 7'(rem_4y >= DW'(cdo_pkg::DAYS_4Y));
    q_100y   = s6_e100y + 3'(rem_100y >= DW'(cdo_pkg::DAYS_100Y));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_era <= s6_era;
      s7_doe <= s6_doe;
      s7_wd  <= s6_wd;
      s7_x   <= s6_doe - DW'(q_4y) + DW'(q_100y) - DW'(s6_last);
    end
  end

  // Stage 8: estimate of the year within the era.
  assign p_year = 42'(s7_x) * 42'(cdo_pkg::R_YEAR);

  always_ff @(posedge clk) begin
    if (en) begin
      s8_era  <= s7_era;
      s8_doe  <= s7_doe;
      s8_x    <= s7_x;
      s8_wd   <= s7_wd;
      s8_yest <= p_year[40:32];
    end
  end

  // Stage 9: correct the year within the era.
  assign rem_year = s8_x - DW'(s8_yest) * DW'(cdo_pkg::DAYS_YEAR);

  always_ff @(posedge clk) begin
    if (en) begin
      s9_era <= s8_era;
      s9_doe <= s8_doe;
      s9_wd  <= s8_wd;
      s9_yoe <= s8_yest + 9'(rem_year >= DW'(cdo_pkg::DAYS_YEAR));
    end
  end

  // Stage 10: day within the March-based year.
  always_comb begin
    cents = 2'(s9_yoe >= 9'(cdo_pkg::CENTURY))
          + 2'(s9_yoe >= 9'(2 * cdo_pkg::CENTURY))
          + 2'(s9_yoe >= 9'(3 * cdo_pkg::CENTURY));
    doy_full = s9_doe - DW'(s9_yoe) * DW'(cdo_pkg::DAYS_YEAR) - DW'(s9_yoe >> 2)
             + DW'(cents);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_era <= s9_era;
      s10_yoe <= s9_yoe;
      s10_wd  <= s9_wd;
      s10_doy <= doy_full[8:0];
    end
  end

  // Stage 11: month by threshold search, then day of month and calendar year.
  always_comb begin
    mp = 4'd0;
    for (int k = 1; k < cdo_pkg::MONTHS; k++) begin
      if (s10_doy >= cdo_pkg::month_start(4'(k))) begin
        mp = 4'(k);
      end
    end
    jan_feb    = (mp >= 4'd10);
    month_calc = jan_feb ? mp - 4'd9 : mp + 4'd3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      month   <= month_calc;
      day     <= 5'(s10_doy - cdo_pkg::month_start(mp) + 9'd1);
      weekday <= s10_wd;
      year    <= $signed(16'(s10_yoe) + 16'(s10_era) * 16'(cdo_pkg::ERA_YEARS)
                         + 16'(jan_feb)) - 16'(cdo_pkg::ERA_YEARS);
    end
  end

endmodule

`default_nettype wire

// ===== design/calendar_date_offset.sv =====
// Top level of the Gregorian date offset block with weekday and date compare.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per clock while s_axis_tready is high and returns one result word per
// input word, in order. The block is a twelve-stage pipeline: three stages turn the base
// date and offset into a day number, eight stages turn the day number back into a date
// through a chain of reciprocal-multiply divisions, and the last stage is the
// output register. The whole pipeline holds when the output word is not taken, and
// s_axis_tready is high whenever the output register is empty or being read, so the
// sustained rate is one word per cycle. A base month or day outside its normal range is
// carried into the year or month. A result outside years 1900 to 9999 raises m_axis_tuser
// and returns the base date as given with weekday zero. The compare flags always use the
// raw base and other fields.
module calendar_date_offset (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // base_year[13:0], base_month[17:14], base_day[22:18], day_offset[38:23],
  // other_year[52:39], other_month[56:53], other_day[61:57], zeros[63:62]
  input  logic [cdo_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // result_year[13:0], result_month[17:14], result_day[22:18], result_weekday[25:23],
  // base_after_other[26], base_before_other[27], base_same_as_other[28], zeros[31:29]
  output logic [cdo_pkg::OUT_W-1:0]   m_axis_tdata,
  // out_of_range[0]
  output logic                        m_axis_tuser
);

  localparam int NS = cdo_pkg::STAGES;

  logic [cdo_pkg::YEAR_W-1:0]          base_year;
  logic [cdo_pkg::MONTH_W-1:0]         base_month;
  logic [cdo_pkg::DAY_W-1:0]           base_day;
  logic signed [cdo_pkg::OFFSET_W-1:0] day_offset;
  logic [cdo_pkg::YEAR_W-1:0]          other_year;
  logic [cdo_pkg::MONTH_W-1:0]         other_month;
  logic [cdo_pkg::DAY_W-1:0]           other_day;

  logic                                adv;
  logic [NS-1:0]                       vld;
  cdo_pkg::side_t                      side_in;
  cdo_pkg::side_t                      side [NS];
  logic [cdo_pkg::DAYNUM_W-1:0]        day_num;
  logic signed [cdo_pkg::RYEAR_W-1:0]  res_year;
  logic [cdo_pkg::MONTH_W-1:0]         res_month;
  logic [cdo_pkg::DAY_W-1:0]           res_day;
  logic [cdo_pkg::WDAY_W-1:0]          res_wday;
  logic                                oor;

  logic                                out_valid;
  logic [cdo_pkg::OUT_W-1:0]           out_data;
  logic                                out_user;

  assign base_year   = s_axis_tdata[13:0];
  assign base_month  = s_axis_tdata[17:14];
  assign base_day    = s_axis_tdata[22:18];
  assign day_offset  = $signed(s_axis_tdata[38:23]);
  assign other_year  = s_axis_tdata[52:39];
  assign other_month = s_axis_tdata[56:53];
  assign other_day   = s_axis_tdata[61:57];

  // Every stage moves together; only a held output word stops the pipeline.
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

  // Fixed field widths make the concatenated compare the same as year, month, day order.
  always_comb begin
    side_in.year    = base_year;
    side_in.month   = base_month;
    side_in.day     = base_day;
    side_in.after   = {base_year, base_month, base_day} > {other_year, other_month, other_day};
    side_in.earlier = {base_year, base_month, base_day} < {other_year, other_month, other_day};
    side_in.same    = {base_year, base_month, base_day} == {other_year, other_month, other_day};
  end

  cdo_to_days u_to_days (
    .clk        (clk),
    .en         (adv),
    .base_year  (base_year),
    .base_month (base_month),
    .base_day   (base_day),
    .day_offset (day_offset),
    .day_num    (day_num)
  );

  cdo_from_days u_from_days (
    .clk     (clk),
    .en      (adv),
    .day_num (day_num),
    .year    (res_year),
    .month   (res_month),
    .day     (res_day),
    .weekday (res_wday)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NS-2:0], s_axis_tvalid};
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_in;
      for (int i = 1; i < NS; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign oor = (res_year < cdo_pkg::YEAR_MIN) || (res_year > cdo_pkg::YEAR_MAX);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_user <= oor;
      if (oor) begin
        out_data <= {3'b000, side[NS-1].same, side[NS-1].earlier, side[NS-1].after,
                     3'b000, side[NS-1].day, side[NS-1].month, side[NS-1].year};
      end else begin
        out_data <= {3'b000, side[NS-1].same, side[NS-1].earlier, side[NS-1].after,
                     res_wday, res_day, res_month, res_year[13:0]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/cdo_checker.sv =====
// Port-level checker for the date offset block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cdo_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tready,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [cdo_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      m_axis_tuser
);

  // A held output word keeps its valid.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // A held output word keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // With the output register empty the pipeline must be able to take a word.
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // An out-of-range result carries weekday zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[25:23] == 3'd0)
    else $error("weekday set on out-of-range result");

  // Exactly one of after, before and same holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot(m_axis_tdata[28:26]))
    else $error("compare flags not exclusive");

endmodule

bind calendar_date_offset cdo_checker u_cdo_checker (.*);

`default_nettype wire

// ===== tb/sv/calendar_date_offset_checker.sv =====
// Checker that predicts each shifted date and compares it with the block's result words.
`timescale 1ns / 1ps

module calendar_date_offset_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [cdo_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [cdo_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      m_axis_tuser,
  output int                        mismatches,
  output int                        outstanding,
  output int                        dates_checked,
  output int                        range_flags
);

  // Days from March 1 of year 0 to January 1, 1970, which was a Thursday.
  localparam longint EPOCH_SHIFT   = 719468;
  localparam longint EPOCH_WEEKDAY = 4;

  typedef struct packed {
    logic [cdo_pkg::YEAR_W-1:0]  year;
    logic [cdo_pkg::MONTH_W-1:0] month;
    logic [cdo_pkg::DAY_W-1:0]   day;
    logic [cdo_pkg::WDAY_W-1:0]  weekday;
    logic                        out_of_range;
    logic                        after;
    logic                        earlier;
    logic                        same;
  } shifted_date_t;

  shifted_date_t expected_dates[$];
  shifted_date_t got_date;
  shifted_date_t want_date;
  int            error_total = 0;
  int            checked_total = 0;
  int            flagged_total = 0;

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  // Day count relative to 1970-01-01, with years counted from March.
  function automatic longint date_to_daynum(input longint y, input longint m, input longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = floor_div(y, cdo_pkg::ERA_YEARS);
    yoe = y - era * cdo_pkg::ERA_YEARS;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * cdo_pkg::DAYS_YEAR + yoe / 4 - yoe / cdo_pkg::CENTURY + doy;
    return era * cdo_pkg::DAYS_400Y + doe - EPOCH_SHIFT;
  endfunction

  function automatic void daynum_to_date(input longint z, output longint y, output longint m,
                                         output longint d);
    longint era, doe, yoe, doy, mp;
    z   = z + EPOCH_SHIFT;
    era = floor_div(z, cdo_pkg::DAYS_400Y);
    doe = z - era * cdo_pkg::DAYS_400Y;
    yoe = (doe - doe / cdo_pkg::DAYS_4Y + doe / cdo_pkg::DAYS_100Y
           - doe / (cdo_pkg::DAYS_400Y - 1)) / cdo_pkg::DAYS_YEAR;
    doy = doe - (cdo_pkg::DAYS_YEAR * yoe + yoe / 4 - yoe / cdo_pkg::CENTURY);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = mp < 10 ? mp + 3 : mp - 9;
    y   = yoe + era * cdo_pkg::ERA_YEARS + (m <= 2 ? 1 : 0);
  endfunction

  function automatic shifted_date_t shift_date(input logic [cdo_pkg::IN_W-1:0] w);
    logic [cdo_pkg::YEAR_W-1:0]          by, oy;
    logic [cdo_pkg::MONTH_W-1:0]         bm, om;
    logic [cdo_pkg::DAY_W-1:0]           bd, od;
    logic signed [cdo_pkg::OFFSET_W-1:0] off;
    longint                              mon0, yy, mm, z, ry, rm, rd, wd;
    shifted_date_t                       r;
    by  = w[13:0];
    bm  = w[17:14];
    bd  = w[22:18];
    off = w[38:23];
    oy  = w[52:39];
    om  = w[56:53];
    od  = w[61:57];
    // Month and day outside their normal range carry into the year and month, as mktime does.
    mon0 = longint'(bm) - 1;
    yy   = longint'(by) + floor_div(mon0, cdo_pkg::MONTHS);
    mm   = mon0 - floor_div(mon0, cdo_pkg::MONTHS) * cdo_pkg::MONTHS + 1;
    z    = date_to_daynum(yy, mm, 1) + (longint'(bd) - 1) + longint'(off);
    daynum_to_date(z, ry, rm, rd);
    if (ry < cdo_pkg::YEAR_MIN || ry > cdo_pkg::YEAR_MAX) begin
      r.year         = by;
      r.month        = bm;
      r.day          = bd;
      r.weekday      = '0;
      r.out_of_range = 1'b1;
    end else begin
      wd             = (z + EPOCH_WEEKDAY)
                     - floor_div(z + EPOCH_WEEKDAY, cdo_pkg::WDAYS) * cdo_pkg::WDAYS;
      r.year         = ry[cdo_pkg::YEAR_W-1:0];
      r.month        = rm[cdo_pkg::MONTH_W-1:0];
      r.day          = rd[cdo_pkg::DAY_W-1:0];
      r.weekday      = wd[cdo_pkg::WDAY_W-1:0];
      r.out_of_range = 1'b0;
    end
    r.after   = (by > oy) || (by == oy && bm > om) || (by == oy && bm == om && bd > od);
    r.earlier = (by < oy) || (by == oy && bm < om) || (by == oy && bm == om && bd < od);
    r.same    = (by == oy) && (bm == om) && (bd == od);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_date.year         = m_axis_tdata[13:0];
        got_date.month        = m_axis_tdata[17:14];
        got_date.day          = m_axis_tdata[22:18];
        got_date.weekday      = m_axis_tdata[25:23];
        got_date.after        = m_axis_tdata[26];
        got_date.earlier      = m_axis_tdata[27];
        got_date.same         = m_axis_tdata[28];
        got_date.out_of_range = m_axis_tuser;
        if (expected_dates.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("%0t: result word with nothing expected: %p", $realtime, got_date);
        end else begin
          want_date = expected_dates.pop_front();
          checked_total++;
          if (want_date.out_of_range) flagged_total++;
          if (got_date !== want_date) begin
            error_total++;
            if (error_total <= 10)
              $display("%0t: mismatch\n  expected %p\n  actual   %p", $realtime, want_date,
                       got_date);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_dates.push_back(shift_date(s_axis_tdata));
    end
    mismatches    <= error_total;
    outstanding   <= expected_dates.size();
    dates_checked <= checked_total;
    range_flags   <= flagged_total;
  end

endmodule

// ===== tb/sv/tb_calendar_date_offset.sv =====
// Testbench top for calendar_date_offset: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_calendar_date_offset;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_TAIL    = 150;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [cdo_pkg::IN_W-1:0]  s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [cdo_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      m_axis_tuser;
  int                        mismatches;
  int                        outstanding;
  int                        dates_checked;
  int                        range_flags;
  bit                        calm = 1'b0;
  logic [cdo_pkg::IN_W-1:0]  directed_words[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calendar_date_offset u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  calendar_date_offset_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .dates_checked (dates_checked),
    .range_flags   (range_flags)
  );

  function automatic logic [cdo_pkg::IN_W-1:0] date_word(input int by, input int bm,
                                                         input int bd, input int off,
                                                         input int oy, input int om,
                                                         input int od);
    return {2'b00, cdo_pkg::DAY_W'(od), cdo_pkg::MONTH_W'(om), cdo_pkg::YEAR_W'(oy),
            cdo_pkg::OFFSET_W'(off), cdo_pkg::DAY_W'(bd), cdo_pkg::MONTH_W'(bm),
            cdo_pkg::YEAR_W'(by)};
  endfunction

  // Mostly valid dates, some close to the year limits, and some with every field random.
  function automatic logic [cdo_pkg::IN_W-1:0] random_date_word();
    int by, bm, bd, off, oy, om, od, pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      if (pick < 60) by = $urandom_range(1900, 9999);
      else if ($urandom_range(0, 1)) by = $urandom_range(1900, 1995);
      else by = $urandom_range(9905, 9999);
      bm = $urandom_range(1, 12);
      bd = ($urandom_range(0, 4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
      if (pick < 60 && $urandom_range(0, 1)) off = int'($urandom_range(0, 800)) - 400;
      else off = $urandom_range(0, 65535);
    end else begin
      by  = $urandom_range(0, 16383);
      bm  = $urandom_range(0, 15);
      bd  = $urandom_range(0, 31);
      off = $urandom_range(0, 65535);
    end
    oy = by;
    om = bm;
    od = bd;
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        case ($urandom_range(0, 2))
          0: oy = $urandom_range(0, 1) ? by + 1 : by - 1;
          1: om = $urandom_range(0, 1) ? bm + 1 : bm - 1;
          default: od = $urandom_range(0, 1) ? bd + 1 : bd - 1;
        endcase
      end
      2: begin
        oy = $urandom_range(1900, 9999);
        om = $urandom_range(1, 12);
        od = $urandom_range(1, 28);
      end
      default: begin
        oy = $urandom_range(0, 16383);
        om = $urandom_range(0, 15);
        od = $urandom_range(0, 31);
      end
    endcase
    return date_word(by, bm, bd, off, oy, om, od);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word was taken.
  task automatic send_date(input logic [cdo_pkg::IN_W-1:0] w, input bit may_idle);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tdata  <= w;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  initial begin
    int cycle_count;
    m_axis_tready = 1'b0;
    cycle_count   = 0;
    forever begin
      @(negedge clk);
      cycle_count++;
      // Every third stretch of cycle_count runs with the output always ready.
      if (!calm && (cycle_count / 500) % 3 != 2 && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    // Leap days, year limits, carries of month and day, offset extremes and compares.
    directed_words.push_back(date_word(2000, 2, 29, 0, 2000, 2, 29));
    directed_words.push_back(date_word(1900, 1, 1, 0, 1899, 12, 31));
    directed_words.push_back(date_word(1900, 1, 1, -1, 1900, 1, 2));
    directed_words.push_back(date_word(9999, 12, 31, 0, 9999, 12, 30));
    directed_words.push_back(date_word(9999, 12, 31, 1, 9999, 11, 31));
    directed_words.push_back(date_word(2024, 1, 31, 32767, 2024, 2, 1));
    directed_words.push_back(date_word(2024, 3, 1, -32768, 2025, 3, 1));
    directed_words.push_back(date_word(1900, 2, 29, 0, 1900, 2, 28));
    directed_words.push_back(date_word(2023, 0, 15, 0, 2023, 0, 15));
    directed_words.push_back(date_word(2023, 13, 1, 0, 2023, 12, 1));
    directed_words.push_back(date_word(2023, 15, 31, 0, 0, 0, 0));
    directed_words.push_back(date_word(2023, 3, 0, 0, 16383, 15, 31));
    directed_words.push_back(date_word(2023, 4, 31, 0, 2023, 4, 30));
    directed_words.push_back(date_word(0, 0, 0, 32767, 0, 0, 0));
    directed_words.push_back(date_word(16383, 15, 31, -32768, 16383, 15, 31));
    directed_words.push_back(date_word(1850, 6, 15, 32767, 1900, 6, 15));
    directed_words.push_back(date_word(10050, 1, 1, -32768, 9999, 1, 1));
    directed_words.push_back(date_word(2000, 12, 31, 1, 2001, 1, 1));
    directed_words.push_back(date_word(2100, 2, 28, 1, 2100, 2, 28));
    directed_words.push_back(date_word(1996, 2, 28, 1, 1996, 3, 28));
    directed_words.push_back(date_word(1970, 1, 1, 0, 1970, 1, 1));
    directed_words.push_back(date_word(1901, 1, 1, -366, 1901, 1, 1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_words[i]) send_date(directed_words[i], 1'b1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
      send_date(random_date_word(), !calm && (i / 64) % 4 != 3);
    end
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (cdo_pkg::STAGES + 8) @(posedge clk);

    $display("Sent %0d directed and %0d random date words; %0d results checked,",
             directed_words.size(), RANDOM_ITEMS, dates_checked);
    $display("%0d of them shifted past the supported years and echoed the base date.",
             range_flags);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
